// File: sv/lpwd_pkg.sv
// Shared types, constants and the window prefill function for the LZSS decoder.
// Depends on nothing; lpwd_window and the decoder unit import it.
`default_nettype none

package lpwd_pkg;

    localparam int WIN_SIZE = 4096;
    localparam int WIN_AW   = $clog2(WIN_SIZE);
    localparam int CNT_W    = 5;

    localparam logic [WIN_AW-1:0] START_POS    = 12'hFEE;
    localparam logic [WIN_AW-1:0] RAMP_UP_BASE = 12'hD00;
    localparam logic [WIN_AW-1:0] RAMP_DN_BASE = 12'hE00;
    localparam logic [WIN_AW-1:0] ZERO_BASE    = 12'hF00;
    localparam logic [WIN_AW-1:0] SPACE_BASE   = 12'hF80;
    localparam logic [7:0]        SPACE_CHAR   = 8'h20;
    localparam logic [CNT_W-1:0]  MIN_MATCH    = 5'd3;

    // ceil(2^16 / 13); exact quotient for every address below the ramps.
    localparam logic [12:0] RECIP_13 = 13'd5042;

    // Stream phase codes: header bytes use their own index 0..7.
    localparam logic [3:0] PH_LEN_LO   = 4'd4;
    localparam logic [3:0] PH_LEN_HI   = 4'd5;
    localparam logic [3:0] PH_ITEM     = 4'd8;
    localparam logic [3:0] PH_REF_HIGH = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [7:0]        wr_data;
    } t_win_req;

    // Contents of a window location that has not been written since restart.
    function automatic logic [7:0] prefill_byte(input logic [WIN_AW-1:0] a);
        logic [24:0] prod;
        logic [7:0]  res;
        begin
            prod = {13'd0, a} * {12'd0, RECIP_13};
            if (a < RAMP_UP_BASE) begin
                res = prod[23:16];
            end else if (a < RAMP_DN_BASE) begin
                res = a[7:0];
            end else if (a < ZERO_BASE) begin
                res = ~a[7:0];
            end else if (a < SPACE_BASE) begin
                res = 8'd0;
            end else if (a < START_POS) begin
                res = SPACE_CHAR;
            end else begin
                res = 8'd0;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/lpwd_if.sv
// Handshake interfaces for the compressed input words and decoded output words.
// Depends on nothing.
`default_nettype none

interface lpwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_stream;

    modport source (output valid, in_byte, start_of_stream, input ready);
    modport sink   (input valid, in_byte, start_of_stream, output ready);
endinterface

interface lpwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       final_byte;

    modport source (output valid, out_byte, last_of_run, final_byte, input ready);
    modport sink   (input valid, out_byte, last_of_run, final_byte, output ready);
endinterface

`default_nettype wire

// File: sv/lpwd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module lpwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/lpwd_window.sv
// History window: RAM, write pointer and fill count that resolves never-written
// locations to the prefill pattern. Depends on lpwd_pkg and lpwd_ram.
`default_nettype none

module lpwd_window (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpwd_pkg::t_win_req i_req,
    output logic      [7:0]         o_rd_data
);
    import lpwd_pkg::*;

    localparam logic [WIN_AW:0] FILL_FULL = (WIN_AW+1)'(WIN_SIZE);

    logic [WIN_AW-1:0] r_wr_pos;
    logic [WIN_AW:0]   r_fill;
    logic              r_hit;
    logic [WIN_AW-1:0] r_rd_addr;
    logic [WIN_AW-1:0] rd_off;
    logic [7:0]        ram_data;

    // Writes run forward from the start position, so the written locations
    // form one contiguous span of r_fill entries beginning there.
    assign rd_off = i_req.rd_addr - START_POS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_wr_pos <= START_POS;
            r_fill   <= '0;
        end else if (i_req.wr_en) begin
            r_wr_pos <= r_wr_pos + 1'b1;
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_hit     <= ({1'b0, rd_off} < r_fill);
            r_rd_addr <= i_req.rd_addr;
        end
    end

    lpwd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr_en),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (i_req.rd_addr),
        .o_rd_data (ram_data)
    );

    assign o_rd_data = r_hit ? ram_data : prefill_byte(r_rd_addr);

endmodule

`default_nettype wire

// File: sv/lzss_prefilled_window_decoder_unit.sv
// LZSS decoder with a prefilled 4096-byte window. Compressed words enter one byte at a
// time; the first eight bytes are a header whose bytes 4 and 5 give the output length.
// Header, flag and reference-low words are each consumed as they are accepted. A literal
// is accepted, then emitted, and a reference copies its bytes one by one, since every
// byte goes through the single window memory as a registered read followed by a write.
// The input is not ready while a literal or reference is being emitted, and emission
// also waits whenever the output register is held by the consumer. A start-of-stream
// word restarts the window at once: never-written locations read back the prefill
// pattern, tracked by a fill count, so no clearing pass is needed after reset.
// Depends on lpwd_pkg, lpwd_if and lpwd_window.
`default_nettype none

module lzss_prefilled_window_decoder_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lpwd_in_if.sink   i_in,
    lpwd_out_if.source o_out
);
    import lpwd_pkg::*;

    t_state            r_state, n_state;
    logic [3:0]        r_phase;
    logic [7:0]        r_flag_bits;
    logic [7:0]        r_flag_mask;
    logic [7:0]        r_ref_low;
    logic [15:0]       r_total;
    logic [15:0]       r_produced;
    logic [WIN_AW-1:0] r_src;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_is_lit;
    logic [7:0]        r_lit;
    logic              r_out_vld;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_final;

    t_win_req          win_req;
    logic [7:0]        win_data;
    logic              in_acc;
    logic              active;
    logic              go_ref;
    logic              go_flag;
    logic              go_lit;
    logic              out_free;
    logic              out_load;
    logic [7:0]        emit_val;
    logic [15:0]       left;
    logic [CNT_W-1:0]  ref_len;
    logic [CNT_W-1:0]  ref_cnt;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign emit_val = r_is_lit ? r_lit : win_data;

    // Decode of the word at the input, valid only when it is accepted.
    assign active  = !i_in.start_of_stream && (r_phase >= PH_ITEM) && (r_produced < r_total);
    assign go_ref  = active && (r_phase == PH_REF_HIGH);
    assign go_flag = active && !go_ref && (r_flag_mask == 8'd0);
    assign go_lit  = active && !go_ref && !go_flag && ((r_flag_bits & r_flag_mask) != 8'd0);

    assign left    = r_total - r_produced;
    assign ref_len = {1'b0, i_in.in_byte[3:0]} + MIN_MATCH;
    assign ref_cnt = ({11'd0, ref_len} > left) ? left[CNT_W-1:0] : ref_len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && go_ref) begin
                    n_state = ST_READ;
                end else if (in_acc && go_lit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_cnt == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        out_load        = (r_state == ST_EMIT) && out_free;
        win_req.clear   = in_acc && i_in.start_of_stream;
        win_req.rd_en   = (r_state == ST_READ);
        win_req.rd_addr = r_src;
        win_req.wr_en   = out_load;
        win_req.wr_data = emit_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 4'd0;
            r_flag_bits <= 8'd0;
            r_flag_mask <= 8'd0;
            r_ref_low   <= 8'd0;
            r_total     <= 16'd0;
            r_produced  <= 16'd0;
            r_cnt       <= '0;
            r_is_lit    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (i_in.start_of_stream) begin
                    // Restart; this word is header byte 0.
                    r_phase     <= 4'd1;
                    r_flag_bits <= 8'd0;
                    r_flag_mask <= 8'd0;
                    r_ref_low   <= 8'd0;
                    r_total     <= 16'd0;
                    r_produced  <= 16'd0;
                end else if (r_phase < PH_ITEM) begin
                    if (r_phase == PH_LEN_LO) begin
                        r_total[7:0] <= i_in.in_byte;
                    end else if (r_phase == PH_LEN_HI) begin
                        r_total[15:8] <= i_in.in_byte;
                    end
                    r_phase <= r_phase + 4'd1;
                end else if (go_ref) begin
                    r_cnt       <= ref_cnt;
                    r_is_lit    <= 1'b0;
                    r_flag_mask <= {r_flag_mask[6:0], 1'b0};
                    r_phase     <= PH_ITEM;
                end else if (go_flag) begin
                    r_flag_bits <= i_in.in_byte;
                    r_flag_mask <= 8'd1;
                end else if (go_lit) begin
                    r_cnt       <= CNT_W'(1);
                    r_is_lit    <= 1'b1;
                    r_flag_mask <= {r_flag_mask[6:0], 1'b0};
                end else if (active) begin
                    r_ref_low <= i_in.in_byte;
                    r_phase   <= PH_REF_HIGH;
                end
            end
            if (out_load) begin
                r_produced <= r_produced + 16'd1;
                r_cnt      <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && go_ref) begin
            r_src <= {i_in.in_byte[7:4], r_ref_low};
        end else if (out_load) begin
            r_src <= r_src + 1'b1;
        end
        if (in_acc && go_lit) begin
            r_lit <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte  <= emit_val;
            r_out_last  <= (r_cnt == CNT_W'(1));
            r_out_final <= ((r_produced + 16'd1) == r_total);
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.final_byte  = r_out_final;

    lpwd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (win_req),
        .o_rd_data (win_data)
    );

    // A run in progress always has bytes left to send.
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt != '0))
        else $error("run in progress with zero count");

    // No byte is emitted beyond the declared length.
    a_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_produced < r_total))
        else $error("byte emitted past declared length");

    // The byte that completes the stream is also the last of its run.
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && ((r_produced + 16'd1) == r_total)) |-> (r_cnt == CNT_W'(1)))
        else $error("final byte not last of its run");

    // A window read is always followed by the emit step that consumes it.
    a_read_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_EMIT))
        else $error("window read not followed by emit");

endmodule

`default_nettype wire
